/* rtl/adll_pkg.sv */
package adll_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOTS    = CAPACITY + 1;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int SLOT_W   = $clog2(SLOTS);

    localparam int CMD_W    = 3;
    localparam int NODE_W   = 10;
    localparam int VAL_W    = 32;
    localparam int LINK_W   = 11;
    localparam int STAT_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD       = 3'd0,
        CMD_SET_ENDS   = 3'd1,
        CMD_INS_AFTER  = 3'd2,
        CMD_INS_BEFORE = 3'd3,
        CMD_REMOVE     = 3'd4,
        CMD_WALK       = 3'd5
    } t_cmd;

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status STAT_OK   = 2'd0;
    localparam t_status STAT_FULL = 2'd1;
    localparam t_status STAT_END  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WR2,
        ST_WALK2
    } t_state;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef struct packed {
        t_slot             next_raddr;
        t_slot             prev_raddr;
        t_idx              val_raddr;
        logic              next_we;
        t_slot             next_waddr;
        t_slot             next_wdata;
        logic              prev_we;
        t_slot             prev_waddr;
        t_slot             prev_wdata;
        logic              val_we;
        t_idx              val_waddr;
        logic [VAL_W-1:0]  val_wdata;
    } t_mem_req;

    typedef struct packed {
        t_slot             next_rdata;
        t_slot             prev_rdata;
        logic [VAL_W-1:0]  val_rdata;
    } t_mem_rsp;

    // a link of none, a negative link or a node beyond the list maps to the sentinel
    function automatic t_slot link_to_slot(input logic [LINK_W-1:0] raw);
        logic [31:0] v;
        v = 32'(raw);
        if (raw[LINK_W-1]) begin
            return '0;
        end
        if (v >= 32'(CAPACITY)) begin
            return '0;
        end
        return SLOT_W'(v + 32'd1);
    endfunction

endpackage

/* rtl/adll_mem.sv */
module adll_mem (
    input  logic                i_clk,
    input  adll_pkg::t_mem_req  i_req,
    output adll_pkg::t_mem_rsp  o_rsp
);
    import adll_pkg::*;

    logic [VAL_W-1:0] mem_val  [CAPACITY];
    t_slot            mem_next [SLOTS];
    t_slot            mem_prev [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_req.next_we) begin
            mem_next[i_req.next_waddr] <= i_req.next_wdata;
        end
        if (i_req.prev_we) begin
            mem_prev[i_req.prev_waddr] <= i_req.prev_wdata;
        end
        if (i_req.val_we) begin
            mem_val[i_req.val_waddr] <= i_req.val_wdata;
        end
        o_rsp.next_rdata <= mem_next[i_req.next_raddr];
        o_rsp.prev_rdata <= mem_prev[i_req.prev_raddr];
        o_rsp.val_rdata  <= mem_val[i_req.val_raddr];
    end

endmodule

/* rtl/adll_ctrl.sv */
module adll_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [adll_pkg::CMD_W-1:0]     i_cmd,
    input  logic [adll_pkg::NODE_W-1:0]    i_node_index,
    input  logic [adll_pkg::VAL_W-1:0]     i_data_value,
    input  logic [adll_pkg::LINK_W-1:0]    i_next_index,
    input  logic [adll_pkg::LINK_W-1:0]    i_prev_index,
    output adll_pkg::t_mem_req             o_req,
    input  adll_pkg::t_mem_rsp             i_rsp,
    output logic                           o_valid,
    output logic [adll_pkg::VAL_W-1:0]     o_result_value,
    output logic [adll_pkg::NODE_W-1:0]    o_result_index,
    output logic [adll_pkg::STAT_W-1:0]    o_status,
    output logic                           o_is_last
);
    import adll_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [NODE_W-1:0] r_node;
    logic [VAL_W-1:0]  r_data;
    t_slot             r_nslot, r_pslot;
    t_slot             r_free, n_free;
    t_slot             r_cursor, n_cursor;
    t_slot             r_link, n_link;
    logic              r_done, n_done;
    logic [VAL_W-1:0]  r_rv, n_rv;
    logic [NODE_W-1:0] r_ri, n_ri;
    t_status           r_st, n_st;
    logic              r_last, n_last;

    logic              w_accept;
    logic              w_in_range;
    logic              w_full;
    t_slot             w_t;
    t_slot             w_new;
    t_slot             w_p0;
    logic [31:0]       w_cnt;
    t_slot             w_in_t;

    assign w_accept   = i_start && (r_state == ST_IDLE);
    assign o_busy     = (r_state != ST_IDLE);
    assign w_in_range = 32'(r_node) < 32'(CAPACITY);
    assign w_full     = 32'(r_free) >= 32'(CAPACITY);
    assign w_t        = SLOT_W'(r_node) + SLOT_W'(1);
    assign w_in_t     = SLOT_W'(i_node_index) + SLOT_W'(1);
    assign w_new      = r_free + SLOT_W'(1);
    // a head of none clears the sentinel's tail link before the tail fix-up
    assign w_p0       = (r_nslot == '0) ? '0 : r_pslot;
    assign w_cnt      = 32'(r_node) + 32'd1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_cmd)
                    CMD_SET_ENDS: n_state = ST_WR2;
                    CMD_INS_AFTER, CMD_INS_BEFORE: begin
                        n_state = (w_in_range && !w_full) ? ST_WR2 : ST_IDLE;
                    end
                    CMD_WALK: begin
                        n_state = (i_rsp.next_rdata == '0) ? ST_IDLE : ST_WALK2;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_WR2:   n_state = ST_IDLE;
            ST_WALK2: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req           = '0;
        o_req.val_wdata = r_data;
        n_free          = r_free;
        n_cursor        = r_cursor;
        n_link          = r_link;
        n_done          = 1'b0;
        n_rv            = '0;
        n_ri            = '0;
        n_st            = STAT_OK;
        n_last          = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req.next_raddr = (t_cmd'(i_cmd) == CMD_WALK) ? r_cursor : w_in_t;
                o_req.prev_raddr = w_in_t;
                o_req.val_raddr  = IDX_W'(i_node_index);
            end
            ST_EXEC: begin
                case (r_cmd)
                    CMD_LOAD: begin
                        n_done = 1'b1;
                        if (w_in_range) begin
                            o_req.val_we     = 1'b1;
                            o_req.val_waddr  = IDX_W'(r_node);
                            o_req.next_we    = 1'b1;
                            o_req.next_waddr = w_t;
                            o_req.next_wdata = r_nslot;
                            o_req.prev_we    = 1'b1;
                            o_req.prev_waddr = w_t;
                            o_req.prev_wdata = r_pslot;
                        end
                    end
                    CMD_SET_ENDS: begin
                        o_req.next_we    = 1'b1;
                        o_req.next_wdata = r_nslot;
                        o_req.prev_we    = 1'b1;
                        o_req.prev_wdata = r_pslot;
                        n_free   = (w_cnt < 32'(CAPACITY)) ? SLOT_W'(w_cnt)
                                                           : SLOT_W'(CAPACITY);
                        n_cursor = '0;
                    end
                    CMD_INS_AFTER, CMD_INS_BEFORE: begin
                        if (!w_in_range) begin
                            n_done = 1'b1;
                        end else if (w_full) begin
                            n_done = 1'b1;
                            n_st   = STAT_FULL;
                        end else begin
                            o_req.val_we     = 1'b1;
                            o_req.val_waddr  = IDX_W'(r_free);
                            o_req.next_we    = 1'b1;
                            o_req.next_waddr = w_new;
                            o_req.prev_we    = 1'b1;
                            o_req.prev_waddr = w_new;
                            if (r_cmd == CMD_INS_AFTER) begin
                                o_req.next_wdata = i_rsp.next_rdata;
                                o_req.prev_wdata = w_t;
                                n_link           = i_rsp.next_rdata;
                            end else begin
                                o_req.next_wdata = w_t;
                                o_req.prev_wdata = i_rsp.prev_rdata;
                                n_link           = i_rsp.prev_rdata;
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        n_done = 1'b1;
                        if (w_in_range) begin
                            o_req.prev_we    = 1'b1;
                            o_req.prev_waddr = i_rsp.next_rdata;
                            o_req.prev_wdata = i_rsp.prev_rdata;
                            o_req.next_we    = 1'b1;
                            o_req.next_waddr = i_rsp.prev_rdata;
                            o_req.next_wdata = i_rsp.next_rdata;
                            n_rv             = i_rsp.val_rdata;
                        end
                    end
                    CMD_WALK: begin
                        n_cursor         = i_rsp.next_rdata;
                        o_req.next_raddr = i_rsp.next_rdata;
                        o_req.val_raddr  = IDX_W'(i_rsp.next_rdata - SLOT_W'(1));
                        if (i_rsp.next_rdata == '0) begin
                            n_done = 1'b1;
                            n_st   = STAT_END;
                        end
                    end
                    default: begin
                        n_done = 1'b1;
                    end
                endcase
            end
            ST_WR2: begin
                n_done        = 1'b1;
                o_req.next_we = 1'b1;
                o_req.prev_we = 1'b1;
                case (r_cmd)
                    CMD_SET_ENDS: begin
                        o_req.prev_waddr = r_nslot;
                        o_req.next_waddr = w_p0;
                    end
                    CMD_INS_AFTER: begin
                        o_req.prev_waddr = r_link;
                        o_req.prev_wdata = w_new;
                        o_req.next_waddr = w_t;
                        o_req.next_wdata = w_new;
                        n_free           = w_new;
                        n_ri             = NODE_W'(r_free);
                    end
                    default: begin
                        o_req.next_waddr = r_link;
                        o_req.next_wdata = w_new;
                        o_req.prev_waddr = w_t;
                        o_req.prev_wdata = w_new;
                        n_free           = w_new;
                        n_ri             = NODE_W'(r_free);
                    end
                endcase
            end
            ST_WALK2: begin
                n_done = 1'b1;
                n_rv   = i_rsp.val_rdata;
                n_last = (i_rsp.next_rdata == '0);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_free   <= '0;
            r_cursor <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_cursor <= n_cursor;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_node  <= i_node_index;
            r_data  <= i_data_value;
            r_nslot <= link_to_slot(i_next_index);
            r_pslot <= link_to_slot(i_prev_index);
        end
        r_link <= n_link;
        if (n_done) begin
            r_rv   <= n_rv;
            r_ri   <= n_ri;
            r_st   <= n_st;
            r_last <= n_last;
        end
    end

    assign o_valid        = r_done;
    assign o_result_value = r_rv;
    assign o_result_index = r_ri;
    assign o_status       = r_st;
    assign o_is_last      = r_last;

endmodule

/* rtl/array_doubly_linked_list_unit.sv */
// the result strobe is registered from the execute state for load, remove, unused codes, an insert
// on a node out of range or on a full list, and a walk step at the end; from a second state otherwise
// a new command is taken only once busy is low again; the second state is a second write to the
// single-write-port link memories, or a second dependent read for a walk step
// reset (synchronous, active low) clears the free slot count, the walk cursor and control;
// the node memories are not cleared; results cannot be stalled by the receiver
module array_doubly_linked_list_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [adll_pkg::CMD_W-1:0]         i_cmd,
    input  logic [adll_pkg::NODE_W-1:0]        i_node_index,
    input  logic signed [adll_pkg::VAL_W-1:0]  i_data_value,
    input  logic signed [adll_pkg::LINK_W-1:0] i_next_index,
    input  logic signed [adll_pkg::LINK_W-1:0] i_prev_index,
    output logic                               o_valid,
    output logic signed [adll_pkg::VAL_W-1:0]  o_result_value,
    output logic [adll_pkg::NODE_W-1:0]        o_result_index,
    output logic [adll_pkg::STAT_W-1:0]        o_status,
    output logic                               o_is_last
);
    import adll_pkg::*;

    t_mem_req         mem_req;
    t_mem_rsp         mem_rsp;
    logic [VAL_W-1:0] res_value;

    adll_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_cmd          (i_cmd),
        .i_node_index   (i_node_index),
        .i_data_value   (i_data_value),
        .i_next_index   (i_next_index),
        .i_prev_index   (i_prev_index),
        .o_req          (mem_req),
        .i_rsp          (mem_rsp),
        .o_valid        (o_valid),
        .o_result_value (res_value),
        .o_result_index (o_result_index),
        .o_status       (o_status),
        .o_is_last      (o_is_last)
    );

    adll_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    assign o_result_value = $signed(res_value);

`ifndef SYNTH
    // each result beat closes a command that held busy
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without a command in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats in a row");

    a_full_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_FULL)) |-> (o_result_index == '0))
        else $error("full status carries a slot index");
`endif

endmodule

/* dv/tb_array_doubly_linked_list_unit.sv */
`timescale 1ns / 100ps

module tb_array_doubly_linked_list_unit;
    import adll_pkg::*;

    localparam int RAND_ITEMS  = 600;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [CMD_W-1:0]  CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_SPARE_7 = 3'd7;
    localparam logic [LINK_W-1:0] LINK_NONE   = '1;
    localparam t_slot             SENTINEL    = '0;
    localparam t_slot             SLOT_LIMIT  = t_slot'(CAPACITY);

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] node;
        logic [VAL_W-1:0]  data;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } t_list_cmd;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [NODE_W-1:0] index;
        t_status           status;
        logic              last;
    } t_list_res;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [CMD_W-1:0]          i_cmd = '0;
    logic [NODE_W-1:0]         i_node_index = '0;
    logic signed [VAL_W-1:0]   i_data_value = '0;
    logic signed [LINK_W-1:0]  i_next_index = '0;
    logic signed [LINK_W-1:0]  i_prev_index = '0;
    logic                      o_valid;
    logic signed [VAL_W-1:0]   o_result_value;
    logic [NODE_W-1:0]         o_result_index;
    logic [STAT_W-1:0]         o_status;
    logic                      o_is_last;

    // shadow of the list memories, with a mark per entry once it has been written
    logic [VAL_W-1:0] node_val [CAPACITY];
    t_slot            next_lnk [SLOTS];
    t_slot            prev_lnk [SLOTS];
    bit               val_set  [CAPACITY];
    bit               next_set [SLOTS];
    bit               prev_set [SLOTS];
    t_slot            alloc_ptr = '0;
    t_slot            walk_pos = '0;

    t_list_cmd cmd_q [$];
    t_list_res expected_q [$];
    t_list_cmd held;
    t_list_res step_res;
    t_list_res want;
    int        n_issued = 0;
    int        n_acc = 0;
    int        n_err = 0;
    int        n_cycles = 0;
    int        n_directed;

    array_doubly_linked_list_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_node_index   (i_node_index),
        .i_data_value   (i_data_value),
        .i_next_index   (i_next_index),
        .i_prev_index   (i_prev_index),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_result_index (o_result_index),
        .o_status       (o_status),
        .o_is_last      (o_is_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_slot decode_link(input logic [LINK_W-1:0] raw);
        if (raw[LINK_W-1] || raw >= LINK_W'(CAPACITY)) begin
            return SENTINEL;
        end
        return t_slot'(raw) + t_slot'(1);
    endfunction

    // applies one command to the shadow list and gives the result it must produce
    function automatic void list_step(input t_list_cmd c, output t_list_res r);
        t_slot t;
        t_slot n;
        t_slot nx;
        t_slot pv;
        r = '0;
        t = t_slot'(c.node) + t_slot'(1);
        case (c.cmd)
            CMD_LOAD: begin
                node_val[c.node] = c.data;
                val_set[c.node]  = 1'b1;
                next_lnk[t]      = decode_link(c.nxt);
                prev_lnk[t]      = decode_link(c.prv);
                next_set[t]      = 1'b1;
                prev_set[t]      = 1'b1;
            end
            CMD_SET_ENDS: begin
                alloc_ptr   = t;
                next_lnk[0] = decode_link(c.nxt);
                prev_lnk[0] = decode_link(c.prv);
                next_set[0] = 1'b1;
                prev_set[0] = 1'b1;
                // a head of none clears the tail link just set, in this order
                prev_lnk[next_lnk[0]] = SENTINEL;
                prev_set[next_lnk[0]] = 1'b1;
                next_lnk[prev_lnk[0]] = SENTINEL;
                next_set[prev_lnk[0]] = 1'b1;
                walk_pos = SENTINEL;
            end
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
                if (alloc_ptr >= SLOT_LIMIT) begin
                    r.status = STAT_FULL;
                end else begin
                    n = alloc_ptr + t_slot'(1);
                    if (c.cmd == CMD_INS_AFTER) begin
                        nx = next_lnk[t];
                        next_lnk[n]  = nx;
                        prev_lnk[n]  = t;
                        prev_lnk[nx] = n;
                        next_lnk[t]  = n;
                        prev_set[nx] = 1'b1;
                    end else begin
                        pv = prev_lnk[t];
                        next_lnk[n]  = t;
                        prev_lnk[n]  = pv;
                        next_lnk[pv] = n;
                        prev_lnk[t]  = n;
                        next_set[pv] = 1'b1;
                    end
                    next_set[n] = 1'b1;
                    prev_set[n] = 1'b1;
                    node_val[t_idx'(alloc_ptr)] = c.data;
                    val_set[t_idx'(alloc_ptr)]  = 1'b1;
                    r.index   = NODE_W'(alloc_ptr);
                    alloc_ptr = alloc_ptr + t_slot'(1);
                end
            end
            CMD_REMOVE: begin
                nx = next_lnk[t];
                pv = prev_lnk[t];
                r.value      = node_val[c.node];
                prev_lnk[nx] = pv;
                next_lnk[pv] = nx;
                prev_set[nx] = 1'b1;
                next_set[pv] = 1'b1;
            end
            CMD_WALK: begin
                walk_pos = next_lnk[walk_pos];
                if (walk_pos == SENTINEL) begin
                    r.status = STAT_END;
                end else begin
                    r.value = node_val[t_idx'(walk_pos - t_slot'(1))];
                    r.last  = (next_lnk[walk_pos] == SENTINEL);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // true when the command only reads memory entries that hold written data
    function automatic bit reads_ok(input t_list_cmd c);
        t_slot t;
        t_slot s;
        t = t_slot'(c.node) + t_slot'(1);
        case (c.cmd)
            CMD_INS_AFTER:  return alloc_ptr >= SLOT_LIMIT || next_set[t];
            CMD_INS_BEFORE: return alloc_ptr >= SLOT_LIMIT || prev_set[t];
            CMD_REMOVE:     return next_set[t] && prev_set[t] && val_set[c.node];
            CMD_WALK: begin
                if (!next_set[walk_pos]) begin
                    return 1'b0;
                end
                s = next_lnk[walk_pos];
                return s == SENTINEL
                    || (val_set[t_idx'(s - t_slot'(1))] && next_set[s]);
            end
            default: return 1'b1;
        endcase
    endfunction

    // the generator works one command ahead of nothing: it needs the state after the last beat
    task automatic wait_idle();
        while (cmd_q.size() != 0 || start) begin
            @(negedge i_clk);
        end
    endtask

    task automatic issue(input logic [CMD_W-1:0] op, input logic [NODE_W-1:0] node,
                         input logic [VAL_W-1:0] data, input logic [LINK_W-1:0] nxt,
                         input logic [LINK_W-1:0] prv);
        t_list_cmd c;
        wait_idle();
        c = '{cmd: op, node: node, data: data, nxt: nxt, prv: prv};
        if (reads_ok(c)) begin
            cmd_q.push_back(c);
            n_issued++;
        end
    endtask

    task automatic issue_on_node(input logic [CMD_W-1:0] op);
        t_list_cmd c;
        int        hi;
        wait_idle();
        hi = (alloc_ptr == '0) ? 1 : int'(alloc_ptr);
        if (hi > CAPACITY) begin
            hi = CAPACITY;
        end
        for (int tries = 0; tries < 16; tries++) begin
            c = '{cmd: op, node: NODE_W'($urandom_range(0, hi - 1)), data: $urandom,
                  nxt: LINK_W'($urandom), prv: LINK_W'($urandom)};
            if (reads_ok(c)) begin
                issue(c.cmd, c.node, c.data, c.nxt, c.prv);
                break;
            end
        end
    endtask

    task automatic issue_walks(input int len);
        for (int k = 0; k < len; k++) begin
            issue(CMD_WALK, '0, $urandom, '0, '0);
        end
    endtask

    // a chain of nodes in random slot order, set as the list, then edits and walks on it
    task automatic run_episode();
        int     order [$];
        int     n;
        int     count;
        int     r;
        int     j;
        int     tmp;
        int     steps;
        logic [LINK_W-1:0] nx;
        logic [LINK_W-1:0] pv;
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
        r = $urandom_range(0, 99);
        n = r < 75 ? $urandom_range(1, 8) : r < 96 ? $urandom_range(9, 32)
                                                   : $urandom_range(33, 64);
        for (int k = 0; k < n; k++) begin
            order.push_back(k);
        end
        for (int k = n - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < n; k++) begin
            nx = (k < n - 1) ? LINK_W'(order[k + 1]) : LINK_NONE;
            pv = (k > 0) ? LINK_W'(order[k - 1]) : LINK_NONE;
            // now and then a broken link
            if ($urandom_range(0, 99) < 4) begin
                nx = LINK_W'($urandom);
            end
            if ($urandom_range(0, 99) < 4) begin
                pv = LINK_W'($urandom);
            end
            issue(CMD_LOAD, NODE_W'(order[k]), $urandom, nx, pv);
        end
        // crowded lists sit at or just below capacity so that inserts run into a full list
        if ($urandom_range(0, 99) < 6) begin
            count = CAPACITY - $urandom_range(0, 3);
        end else begin
            count = n + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        end
        head = LINK_W'(order[0]);
        tail = LINK_W'(order[n - 1]);
        if ($urandom_range(0, 99) < 4) begin
            head = LINK_W'($urandom);
        end
        if ($urandom_range(0, 99) < 4) begin
            tail = LINK_W'($urandom);
        end
        issue(CMD_SET_ENDS, NODE_W'(count - 1), $urandom, head, tail);
        steps = $urandom_range(4, 24);
        for (int s = 0; s < steps; s++) begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                issue_on_node(CMD_INS_AFTER);
            end else if (r < 40) begin
                issue_on_node(CMD_INS_BEFORE);
            end else if (r < 54) begin
                issue_on_node(CMD_REMOVE);
            end else if (r < 86) begin
                issue_walks($urandom_range(1, n + 4));
            end else if (r < 94) begin
                issue(CMD_LOAD, NODE_W'($urandom), $urandom, LINK_W'($urandom),
                      LINK_W'($urandom));
            end else begin
                issue(r[0] ? CMD_SPARE_6 : CMD_SPARE_7, NODE_W'($urandom), $urandom,
                      LINK_W'($urandom), LINK_W'($urandom));
            end
        end
    endtask

    // driver: a beat is taken at an edge with start high and busy low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                list_step(held, step_res);
                expected_q.push_back(step_res);
                n_acc++;
            end
            if ((!start || !busy) && cmd_q.size() != 0
                && $urandom_range(0, 99) >= (n_acc < 210 ? 34 : n_acc < 420 ? 81 : 0)) begin
                held = cmd_q.pop_front();
                start        <= 1'b1;
                i_cmd        <= held.cmd;
                i_node_index <= held.node;
                i_data_value <= held.data;
                i_next_index <= held.nxt;
                i_prev_index <= held.prv;
            end else if (start && !busy) begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
            n_err++;
        end
    endtask

    // monitor: results cannot be held off, so every strobe is a beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h %0d %0d %0b",
                         $time, o_result_value, o_result_index, o_status, o_is_last);
                n_err++;
            end else begin
                want = expected_q.pop_front();
                check_field("result_value", want.value, o_result_value);
                check_field("result_index", 32'(want.index), 32'(o_result_index));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("is_last", 32'(want.last), 32'(o_is_last));
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_array_doubly_linked_list_unit: errors");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes of value and links, out-of-range link codes
        issue(CMD_LOAD, 10'd0, 32'h7FFF_FFFF, 11'd1, LINK_NONE);
        issue(CMD_LOAD, 10'd1, 32'h8000_0000, 11'd2, 11'd0);
        issue(CMD_LOAD, 10'd2, 32'h0000_0000, LINK_NONE, 11'd1);
        issue(CMD_LOAD, 10'd1023, 32'hFFFF_FFFF, 11'd1023, 11'h400);
        issue(CMD_LOAD, 10'd3, 32'h5555_AAAA, 11'h2AA, 11'h555);
        issue(CMD_SET_ENDS, 10'd2, 32'hAAAA_5555, 11'd0, 11'd2);
        // walk to the end and past it
        issue_walks(4);
        issue(CMD_INS_AFTER, 10'd2, 32'h1234_5678, '0, '0);
        issue(CMD_INS_BEFORE, 10'd0, 32'hEDCB_A987, '0, '0);
        issue(CMD_REMOVE, 10'd1, '0, '0, '0);
        // removing it again, no longer in the list
        issue(CMD_REMOVE, 10'd1, '0, '0, '0);
        issue(CMD_SPARE_6, 10'h3FF, 32'hFFFF_FFFF, LINK_NONE, LINK_NONE);
        issue(CMD_SPARE_7, 10'h155, 32'h0F0F_0F0F, 11'h7AA, 11'h055);
        // walk restarts at the head after an end
        issue_walks(4);
        // empty list with every slot taken
        issue(CMD_SET_ENDS, 10'd1023, '0, LINK_NONE, 11'd1023);
        issue_walks(1);
        issue(CMD_INS_AFTER, 10'd0, 32'hDEAD_BEEF, '0, '0);
        issue(CMD_INS_BEFORE, 10'd1023, 32'hBEEF_DEAD, '0, '0);
        issue(CMD_SET_ENDS, 10'd4, '0, 11'd0, 11'd2);
        issue(CMD_INS_AFTER, 10'd1023, 32'h0000_0001, '0, '0);
        issue(CMD_REMOVE, 10'd1023, '0, '0, '0);
        n_directed = n_issued;

        while (n_issued < n_directed + RAND_ITEMS) begin
            run_episode();
        end

        while (cmd_q.size() != 0 || start || expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb_array_doubly_linked_list_unit: clean");
        end else begin
            $display("tb_array_doubly_linked_list_unit: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/adll_pkg.sv
rtl/adll_mem.sv
rtl/adll_ctrl.sv
rtl/array_doubly_linked_list_unit.sv
dv/tb_array_doubly_linked_list_unit.sv
